@@ rtl/nearest_speaker_slot_admission_top_defines.svh @@
// Assertion macros for the talker slot admission block.
`ifndef NEAREST_SPEAKER_SLOT_ADMISSION_TOP_DEFINES_SVH
`define NEAREST_SPEAKER_SLOT_ADMISSION_TOP_DEFINES_SVH

// same-cycle implication
`define NSSA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NSSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/nssa_pkg.sv @@
// Shared constants and types for the talker slot admission block.
`timescale 1ns / 1ps
package nssa_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int CMD_W     = 2;
   localparam int KIND_W    = 3;
   localparam int SLOT_W    = 3;
   localparam int SPK_W     = 64;
   localparam int DIST_W    = 32;
   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 16;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 72;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_HIT     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EVICT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_REMOVED = 3'd5;
   localparam logic [KIND_W-1:0] KIND_NOTHING = 3'd6;

   typedef struct packed {
      logic [SPK_W-1:0]  spk;
      logic [DIST_W-1:0] distance;
      logic              unpl;
      logic [TIME_W-1:0] last_time;
   } slot_entry_type;

   localparam int ENTRY_W = SPK_W + DIST_W + 1 + TIME_W;

endpackage

@@ rtl/nearest_speaker_slot_admission_top.sv @@
// Talker slot admission: slot table walk, farthest-first eviction, timeouts.
`timescale 1ns / 1ps
// Each request beat is accepted, walked slot by slot while the walk reads the
// slot RAM through its single read port, then decided and written back, and its
// final result is handed over when the result side is ready. A tick that
// releases several slots holds its walk while an earlier release beat waits on
// rsp_tready. Slot occupancy lives in per-slot valid flops cleared by reset, so
// no clearing pass is needed; a free slot reads as speaker 0, distance 0,
// unplaced. Results carry kind in rsp_tuser, tlast marks the final beat of each
// request. silence_timeout is written on the csr channel and resets to 1000; the
// user must write it only while the block is idle; the block does not enforce it.
`include "nearest_speaker_slot_admission_top_defines.svh"
module nearest_speaker_slot_admission_top import nssa_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // speaker, dist_sq, placed, now_time
   input  logic [CMD_W-1:0]      req_tuser,  // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // slot, slot_valid, released_id
   output logic [KIND_W-1:0]     rsp_tuser,  // kind
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TIMEOUT_W-1:0]  csr_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IW-1:0] i);
      logic [XW-1:0] x;
      x = XW'(i);
      return x[SLOT_W-1:0];
   endfunction

   logic [1:0]           state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [TIMEOUT_W-1:0] tmo_ff, tmo_in;
   logic [SLOTS-1:0]     vld_ff, vld_in;

   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [SPK_W-1:0]     spk_ff, spk_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic                 unpl_ff, unpl_in;
   logic [TIME_W-1:0]    now_ff, now_in;

   logic                 hit_fnd_ff, hit_fnd_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   logic [TIME_W-1:0]    hit_time_ff, hit_time_in;
   logic                 free_fnd_ff, free_fnd_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic [IW-1:0]        far_idx_ff, far_idx_in;
   logic [DIST_W-1:0]    far_dist_ff, far_dist_in;
   logic                 far_unpl_ff, far_unpl_in;
   logic [SPK_W-1:0]     far_spk_ff, far_spk_in;

   logic                 pend_vld_ff, pend_vld_in;
   logic [KIND_W-1:0]    pend_kind_ff, pend_kind_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic                 pend_sv_ff, pend_sv_in;
   logic [SPK_W-1:0]     pend_rel_ff, pend_rel_in;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_sv_ff, rsp_sv_in;
   logic [SPK_W-1:0]     rsp_rel_ff, rsp_rel_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   slot_entry_type       ram_wdata;
   logic [ENTRY_W-1:0]   ram_rdata;
   slot_entry_type       ent;

   logic                 e_v;
   logic [SPK_W-1:0]     e_spk;
   logic [DIST_W-1:0]    e_dist;
   logic                 e_unpl;
   logic [TIME_W-1:0]    age;
   logic                 expired;
   logic                 out_free;
   logic                 advance;
   logic [DIST_W+2:0]    d6;
   logic [DIST_W+2:0]    f5;
   logic                 evict;

   nssa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   assign ent      = slot_entry_type'(ram_rdata);
   assign e_v      = vld_ff[idx_ff];
   assign e_spk    = e_v ? ent.spk : '0;
   assign e_dist   = e_v ? ent.distance : '0;
   assign e_unpl   = e_v ? ent.unpl : 1'b1;
   assign age      = now_ff - ent.last_time;
   assign expired  = e_v && (age > {{(TIME_W-TIMEOUT_W){1'b0}}, tmo_ff});
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign d6       = ({3'b000, dist_ff} << 2) + ({3'b000, dist_ff} << 1);
   assign f5       = ({3'b000, far_dist_ff} << 2) + {3'b000, far_dist_ff};
   assign evict    = !unpl_ff && (far_unpl_ff || (d6 < f5));

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_rel_ff, rsp_sv_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      tmo_in       = tmo_ff;
      vld_in       = vld_ff;
      cmd_in       = cmd_ff;
      spk_in       = spk_ff;
      dist_in      = dist_ff;
      unpl_in      = unpl_ff;
      now_in       = now_ff;
      hit_fnd_in   = hit_fnd_ff;
      hit_idx_in   = hit_idx_ff;
      hit_time_in  = hit_time_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      far_idx_in   = far_idx_ff;
      far_dist_in  = far_dist_ff;
      far_unpl_in  = far_unpl_ff;
      far_spk_in   = far_spk_ff;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_slot_in = pend_slot_ff;
      pend_sv_in   = pend_sv_ff;
      pend_rel_in  = pend_rel_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = hit_idx_ff;
      ram_wdata    = '{spk: spk_ff, distance: dist_ff, unpl: unpl_ff, last_time: now_ff};
      advance      = 1'b1;

      if (csr_valid) begin
         tmo_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_tvalid) begin
               cmd_in      = req_tuser;
               spk_in      = req_tdata[63:0];
               dist_in     = req_tdata[95:64];
               unpl_in     = !req_tdata[96];
               now_in      = req_tdata[128:97];
               hit_fnd_in  = 1'b0;
               free_fnd_in = 1'b0;
               far_unpl_in = 1'b0;
               pend_vld_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmd_ff == CMD_TICK) begin
               if (expired) begin
                  if (pend_vld_ff && !out_free) begin
                     advance = 1'b0;
                  end else begin
                     if (pend_vld_ff) begin
                        rsp_vld_in  = 1'b1;
                        rsp_kind_in = pend_kind_ff;
                        rsp_slot_in = pend_slot_ff;
                        rsp_sv_in   = pend_sv_ff;
                        rsp_rel_in  = pend_rel_ff;
                        rsp_last_in = 1'b0;
                     end
                     pend_vld_in    = 1'b1;
                     pend_kind_in   = KIND_TIMEOUT;
                     pend_slot_in   = slot_of(idx_ff);
                     pend_sv_in     = 1'b1;
                     pend_rel_in    = ent.spk;
                     vld_in[idx_ff] = 1'b0;
                  end
               end
            end else begin
               if (!hit_fnd_ff && e_v && (e_spk == spk_ff)) begin
                  hit_fnd_in  = 1'b1;
                  hit_idx_in  = idx_ff;
                  hit_time_in = ent.last_time;
               end
               if (!free_fnd_ff && !e_v) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = idx_ff;
               end
               if ((idx_ff == '0) || (!far_unpl_ff && (e_unpl || (e_dist > far_dist_ff)))) begin
                  far_idx_in  = idx_ff;
                  far_dist_in = e_dist;
                  far_unpl_in = e_unpl;
                  far_spk_in  = e_spk;
               end
            end
            if (advance) begin
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  state_in = ST_DECIDE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            idx_in       = '0;
            state_in     = ST_EMIT;
            pend_vld_in  = 1'b1;
            pend_kind_in = KIND_NOTHING;
            pend_slot_in = '0;
            pend_sv_in   = 1'b0;
            pend_rel_in  = '0;
            if (cmd_ff == CMD_TICK) begin
               pend_kind_in = pend_vld_ff ? pend_kind_ff : KIND_NOTHING;
               pend_slot_in = pend_vld_ff ? pend_slot_ff : '0;
               pend_sv_in   = pend_vld_ff && pend_sv_ff;
               pend_rel_in  = pend_vld_ff ? pend_rel_ff : '0;
            end else if (spk_ff != '0) begin
               case (cmd_ff)
                  CMD_FRAME: begin
                     if (hit_fnd_ff) begin
                        ram_we       = 1'b1;
                        pend_kind_in = KIND_HIT;
                        pend_slot_in = slot_of(hit_idx_ff);
                        pend_sv_in   = 1'b1;
                     end else if (free_fnd_ff) begin
                        ram_we              = 1'b1;
                        ram_waddr           = free_idx_ff;
                        vld_in[free_idx_ff] = 1'b1;
                        pend_kind_in        = KIND_FREE;
                        pend_slot_in        = slot_of(free_idx_ff);
                        pend_sv_in          = 1'b1;
                     end else if (evict) begin
                        ram_we       = 1'b1;
                        ram_waddr    = far_idx_ff;
                        pend_kind_in = KIND_EVICT;
                        pend_slot_in = slot_of(far_idx_ff);
                        pend_sv_in   = 1'b1;
                        pend_rel_in  = far_spk_ff;
                     end else begin
                        pend_kind_in = KIND_REFUSED;
                     end
                  end
                  CMD_UPDATE: begin
                     if (hit_fnd_ff) begin
                        ram_we              = 1'b1;
                        ram_wdata.last_time = hit_time_ff;
                        pend_kind_in        = KIND_HIT;
                        pend_slot_in        = slot_of(hit_idx_ff);
                        pend_sv_in          = 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit_fnd_ff) begin
                        vld_in[hit_idx_ff] = 1'b0;
                        pend_kind_in       = KIND_REMOVED;
                        pend_slot_in       = slot_of(hit_idx_ff);
                        pend_sv_in         = 1'b1;
                        pend_rel_in        = spk_ff;
                     end
                  end
                  default: begin
                     pend_kind_in = KIND_NOTHING;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            idx_in = '0;
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = pend_kind_ff;
               rsp_slot_in = pend_slot_ff;
               rsp_sv_in   = pend_sv_ff;
               rsp_rel_in  = pend_rel_ff;
               rsp_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         tmo_ff      <= TIMEOUT_RESET;
         vld_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         hit_fnd_ff  <= 1'b0;
         free_fnd_ff <= 1'b0;
         far_unpl_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         tmo_ff      <= tmo_in;
         vld_ff      <= vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         hit_fnd_ff  <= hit_fnd_in;
         free_fnd_ff <= free_fnd_in;
         far_unpl_ff <= far_unpl_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      spk_ff       <= spk_in;
      dist_ff      <= dist_in;
      unpl_ff      <= unpl_in;
      now_ff       <= now_in;
      hit_idx_ff   <= hit_idx_in;
      hit_time_ff  <= hit_time_in;
      free_idx_ff  <= free_idx_in;
      far_idx_ff   <= far_idx_in;
      far_dist_ff  <= far_dist_in;
      far_spk_ff   <= far_spk_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      pend_sv_ff   <= pend_sv_in;
      pend_rel_ff  <= pend_rel_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_sv_ff    <= rsp_sv_in;
      rsp_rel_ff   <= rsp_rel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `NSSA_ASSERT_NEXT(a_accept_walk, req_tvalid && req_tready, (state_ff == ST_SCAN) && (idx_ff == '0), "accepted beat did not start the slot walk at slot zero")
   `NSSA_ASSERT_NOW(a_write_decide, ram_we, state_ff == ST_DECIDE, "slot RAM written outside the decide step")
   `NSSA_ASSERT_NEXT(a_decide_pend, state_ff == ST_DECIDE, pend_vld_ff && (state_ff == ST_EMIT), "decide step left no final result")
   `NSSA_ASSERT_NOW(a_idle_clean, state_ff == ST_IDLE, !pend_vld_ff, "pending result left behind in idle")

endmodule

@@ rtl/nssa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ test/nearest_speaker_slot_admission_top_tb.sv @@
// Testbench for the talker slot admission block: predictor, checker, random traffic.
`timescale 1ns / 1ps
module nearest_speaker_slot_admission_top_tb import nssa_pkg::*; ();

   localparam int NSLOT          = SLOTS_DEFAULT;
   localparam int POOL_SIZE      = 12;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 72;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 30;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic              slot_valid;
      logic [SPK_W-1:0]  released;
      logic              last;
   } outcome_type;

   class slot_table_model;
      logic [SPK_W-1:0]     spk [NSLOT];
      logic [DIST_W-1:0]    distance [NSLOT];
      logic                 unpl [NSLOT];
      logic [TIME_W-1:0]    last_time [NSLOT];
      logic [TIMEOUT_W-1:0] timeout;
      outcome_type          pending_outcomes [$];
      int                   mismatches;

      function new();
         timeout = TIMEOUT_RESET;
         mismatches = 0;
         for (int i = 0; i < NSLOT; i++) release_slot(i);
      endfunction

      function void release_slot(int i);
         spk[i] = '0;
         distance[i] = '0;
         unpl[i] = 1'b1;
         last_time[i] = '0;
      endfunction

      function int lookup(logic [SPK_W-1:0] id);
         for (int i = 0; i < NSLOT; i++)
            if (spk[i] == id) return i;
         return -1;
      endfunction

      function void occupy(int i, logic [SPK_W-1:0] id, logic [DIST_W-1:0] d, logic u,
                           logic [TIME_W-1:0] now);
         spk[i] = id;
         distance[i] = d;
         unpl[i] = u;
         last_time[i] = now;
      endfunction

      function void expect_beat(logic [KIND_W-1:0] kind, int slot, bit valid,
                                logic [SPK_W-1:0] rel);
         outcome_type o;
         o.kind = kind;
         o.slot = valid ? slot[SLOT_W-1:0] : '0;
         o.slot_valid = valid;
         o.released = rel;
         o.last = 1'b0;
         pending_outcomes = {pending_outcomes, o};
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [SPK_W-1:0] id,
                                 logic [DIST_W-1:0] d, logic placed, logic [TIME_W-1:0] now);
         int first;
         int s;
         int far;
         bit evict;
         logic u;
         logic [TIME_W-1:0] age;
         logic [SPK_W-1:0] rel;
         longint unsigned lhs;
         longint unsigned rhs;
         first = pending_outcomes.size();
         u = ~placed;
         if (cmd == CMD_TICK) begin
            for (int i = 0; i < NSLOT; i++) begin
               if (spk[i] == '0) continue;
               age = now - last_time[i];
               if (age > {16'b0, timeout}) begin
                  rel = spk[i];
                  release_slot(i);
                  expect_beat(KIND_TIMEOUT, i, 1'b1, rel);
               end
            end
            if (pending_outcomes.size() == first) expect_beat(KIND_NOTHING, 0, 1'b0, '0);
         end else if (id == '0) begin
            expect_beat(KIND_NOTHING, 0, 1'b0, '0);
         end else if (cmd == CMD_FRAME) begin
            s = lookup(id);
            if (s >= 0) begin
               occupy(s, id, d, u, now);
               expect_beat(KIND_HIT, s, 1'b1, '0);
            end else begin
               s = lookup('0);
               if (s >= 0) begin
                  occupy(s, id, d, u, now);
                  expect_beat(KIND_FREE, s, 1'b1, '0);
               end else begin
                  far = 0;
                  for (int i = 1; i < NSLOT; i++) begin
                     if (unpl[far]) break;
                     if (unpl[i] || distance[i] > distance[far]) far = i;
                  end
                  lhs = 64'(d) * 6;
                  rhs = 64'(distance[far]) * 5;
                  if (u) evict = 1'b0;
                  else if (unpl[far]) evict = 1'b1;
                  else evict = lhs < rhs;
                  if (evict) begin
                     rel = spk[far];
                     occupy(far, id, d, u, now);
                     expect_beat(KIND_EVICT, far, 1'b1, rel);
                  end else begin
                     expect_beat(KIND_REFUSED, 0, 1'b0, '0);
                  end
               end
            end
         end else if (cmd == CMD_UPDATE) begin
            s = lookup(id);
            if (s >= 0) begin
               distance[s] = d;
               unpl[s] = u;
               expect_beat(KIND_HIT, s, 1'b1, '0);
            end else begin
               expect_beat(KIND_NOTHING, 0, 1'b0, '0);
            end
         end else begin
            s = lookup(id);
            if (s >= 0) begin
               release_slot(s);
               expect_beat(KIND_REMOVED, s, 1'b1, id);
            end else begin
               expect_beat(KIND_NOTHING, 0, 1'b0, '0);
            end
         end
         pending_outcomes[pending_outcomes.size()-1].last = 1'b1;
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: kind %0d slot %0d valid %0b released %h last %0b",
                        got.kind, got.slot, got.slot_valid, got.released, got.last);
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.kind !== want.kind || got.slot !== want.slot ||
             got.slot_valid !== want.slot_valid || got.released !== want.released ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch (exp/got): kind %0d/%0d slot %0d/%0d valid %0b/%0b",
                         " rel %h/%h last %0b/%0b"},
                        want.kind, got.kind, want.slot, got.slot, want.slot_valid, got.slot_valid,
                        want.released, got.released, want.last, got.last);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // speaker, dist_sq, placed, now_time
   logic [CMD_W-1:0]      req_tuser = CMD_FRAME;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // slot, slot_valid, released_id
   logic [KIND_W-1:0]     rsp_tuser;   // kind
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TIMEOUT_W-1:0]  csr_data = '0;

   slot_table_model talkers = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;
   logic [SPK_W-1:0]  speaker_pool [POOL_SIZE];
   logic [TIME_W-1:0] cur_time;

   nearest_speaker_slot_admission_top #(.SLOTS(NSLOT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin : rsp_side
      outcome_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.slot = rsp_tdata[2:0];
         got.slot_valid = rsp_tdata[3];
         got.released = rsp_tdata[67:4];
         got.last = rsp_tlast;
         talkers.check_result(got);
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_req(logic [CMD_W-1:0] cmd, logic [SPK_W-1:0] id, logic [DIST_W-1:0] d,
                           logic placed, logic [TIME_W-1:0] now);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'b0, now, placed, d, id};
      do @(posedge clock); while (!req_tready);
      talkers.note_request(cmd, id, d, placed, now);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (talkers.pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
      repeat (16) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      talkers.timeout = value;
   endtask

   task automatic random_item();
      int r;
      logic [CMD_W-1:0]  cmd;
      logic [SPK_W-1:0]  id;
      logic [DIST_W-1:0] d;
      logic              placed;
      logic [TIME_W-1:0] now;
      r = $urandom_range(0, 99);
      if (r < 55) cmd = CMD_FRAME;
      else if (r < 68) cmd = CMD_UPDATE;
      else if (r < 80) cmd = CMD_REMOVE;
      else cmd = CMD_TICK;
      r = $urandom_range(0, 99);
      if (r < 5) id = '0;
      else if (r < 10) id = {$urandom, $urandom};
      else id = speaker_pool[$urandom_range(0, POOL_SIZE-1)];
      r = $urandom_range(0, 99);
      if (r < 40) d = $urandom_range(0, 4000);
      else if (r < 70) d = $urandom;
      else if (r < 80) d = '0;
      else if (r < 90) d = '1;
      else d = 32'hC000_0000 + $urandom_range(0, 32'h1000_0000);
      placed = ($urandom_range(0, 99) < 85);
      r = $urandom_range(0, 99);
      if (r < 3) cur_time = cur_time + $urandom;
      else cur_time = cur_time + $urandom_range(0, int'(talkers.timeout) / 5 + 2);
      now = ($urandom_range(0, 99) < 3) ? $urandom : cur_time;
      send_req(cmd, id, d, placed, now);
   endtask

   initial begin
      logic [TIMEOUT_W-1:0] timeouts [PHASES];
      for (int i = 0; i < POOL_SIZE; i++)
         do speaker_pool[i] = {$urandom, $urandom}; while (speaker_pool[i] == '0);
      speaker_pool[0] = 64'h1;
      speaker_pool[1] = '1;
      speaker_pool[2] = 64'h8000_0000_0000_0000;
      timeouts[0] = 16'd0;
      timeouts[1] = 16'hFFFF;
      timeouts[2] = 16'd1;
      timeouts[3] = 16'd1000;
      timeouts[4] = 16'($urandom_range(2, 300));
      timeouts[5] = 16'($urandom_range(1, 65535));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // speaker zero and unknown speakers on an empty table
      send_req(CMD_FRAME, '0, 32'd5, 1'b1, 32'd100);
      send_req(CMD_UPDATE, '0, 32'd5, 1'b1, 32'd100);
      send_req(CMD_REMOVE, '0, 32'd5, 1'b1, 32'd100);
      send_req(CMD_UPDATE, speaker_pool[0], 32'd5, 1'b1, 32'd100);
      send_req(CMD_REMOVE, speaker_pool[0], 32'd5, 1'b1, 32'd100);
      send_req(CMD_TICK, speaker_pool[5], 32'd0, 1'b0, 32'd100);
      // fill the table; one unplaced talker, a distance tie
      send_req(CMD_FRAME, speaker_pool[0], 32'd0, 1'b1, 32'd100);
      send_req(CMD_FRAME, speaker_pool[1], 32'hFFFF_FFFF, 1'b1, 32'd100);
      send_req(CMD_FRAME, speaker_pool[2], 32'd500, 1'b1, 32'd100);
      send_req(CMD_FRAME, speaker_pool[3], 32'd500, 1'b1, 32'd100);
      send_req(CMD_FRAME, speaker_pool[4], 32'd1000, 1'b1, 32'd100);
      send_req(CMD_FRAME, speaker_pool[5], 32'd123, 1'b0, 32'd100);
      send_req(CMD_FRAME, speaker_pool[6], 32'd7, 1'b1, 32'd100);
      send_req(CMD_FRAME, speaker_pool[7], 32'h8000_0000, 1'b1, 32'd100);
      send_req(CMD_FRAME, speaker_pool[2], 32'd600, 1'b1, 32'd500);
      send_req(CMD_UPDATE, speaker_pool[3], 32'd400, 1'b1, 32'd600);
      // unplaced newcomer is refused, placed one evicts the unplaced slot
      send_req(CMD_FRAME, speaker_pool[8], 32'd0, 1'b0, 32'd700);
      send_req(CMD_FRAME, speaker_pool[8], 32'hFFFF_FFFF, 1'b1, 32'd700);
      // hysteresis boundary against the farthest placed slot
      send_req(CMD_FRAME, speaker_pool[9], 32'd3579139413, 1'b1, 32'd700);
      send_req(CMD_FRAME, speaker_pool[9], 32'd3579139412, 1'b1, 32'd700);
      send_req(CMD_REMOVE, speaker_pool[4], 32'd0, 1'b1, 32'd700);
      send_req(CMD_FRAME, speaker_pool[10], 32'd9, 1'b1, 32'd700);
      // age equal to the timeout stays, one more releases several
      send_req(CMD_TICK, '0, 32'd0, 1'b1, 32'd1100);
      send_req(CMD_TICK, '0, 32'd0, 1'b1, 32'd1101);
      // time wraps
      send_req(CMD_FRAME, speaker_pool[11], 32'd3, 1'b1, 32'hFFFF_FFF0);
      send_req(CMD_TICK, '0, 32'd0, 1'b1, 32'h0000_0010);
      cur_time = 32'h0000_0010;

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         write_timeout(timeouts[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
            default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (talkers.mismatches == 0 && talkers.pending_outcomes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
